>>> rtl/ioct_pkg.sv
// Shared types and constants of the in-order completion tracker.
package ioct_pkg;

  // Default number of pending entries
  localparam int PENDING_DEPTH = 16;

  // Field widths
  localparam int ID_W   = 8;
  localparam int TYPE_W = 8;
  localparam int TICK_W = 32;

  // Timeout register value after reset
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd90;

  // Request kinds
  typedef enum logic [1:0] {
    CMD_ISSUE = 2'd0,
    CMD_RESP  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_kind_t;

  // Reply kinds
  typedef enum logic [1:0] {
    RESP_DONE    = 2'd0,
    RESP_ERROR   = 2'd1,
    RESP_ESTOP   = 2'd2,
    RESP_UNKNOWN = 2'd3
  } resp_kind_t;

  // Fault codes
  typedef enum logic [2:0] {
    FC_UNKNOWN    = 3'd0,
    FC_OOO_DONE   = 3'd1,
    FC_UNEXPECTED = 3'd2,
    FC_TIMEOUT    = 3'd3,
    FC_ERR_REPLY  = 3'd4
  } fault_code_t;

  // Control from the tracker to the ID queue
  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] wdata;
  } fifo_ctl_t;

  // Control from the tracker to the timeout counter
  typedef struct packed {
    logic clear;
    logic tick;
  } tmr_ctl_t;

endpackage

>>> rtl/ioct_if.sv
// Request and result channel interfaces of the in-order completion tracker.
interface ioct_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic [ioct_pkg::TYPE_W-1:0]  cmd_type;
  logic [1:0]                   resp_type;
  logic [ioct_pkg::ID_W-1:0]    resp_id;

  modport source (output valid, cmd, cmd_type, resp_type, resp_id, input ready);
  modport sink   (input valid, cmd, cmd_type, resp_type, resp_id, output ready);
endinterface

interface ioct_out_if #(
  parameter int CNT_W = 5
);
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic [ioct_pkg::ID_W-1:0]    send_id;
  logic [ioct_pkg::TYPE_W-1:0]  send_type;
  logic                         done_valid;
  logic [ioct_pkg::ID_W-1:0]    done_id;
  logic                         fault;
  logic [2:0]                   fault_code;
  logic [CNT_W-1:0]             pending_count;

  modport source (output valid, accepted, send_id, send_type, done_valid, done_id,
                  fault, fault_code, pending_count, input ready);
  modport sink   (input valid, accepted, send_id, send_type, done_valid, done_id,
                  fault, fault_code, pending_count, output ready);
endinterface

>>> rtl/in_order_completion_tracker.sv
// In-order completion tracker: per-request decode, fault state and result register.
// The result of a request is registered and presented in the cycle after it is accepted.
// Throughput: one request per cycle; ready is high while the result register is
// empty or its result is taken in the same cycle.
// Reset (synchronous, active low) clears the ID counter, queue pointers, tick count
// and fault, and loads the timeout with 90; queue storage is not cleared.
module in_order_completion_tracker #(
  parameter int PENDING_DEPTH = ioct_pkg::PENDING_DEPTH,
  parameter int CNT_W         = $clog2(PENDING_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ioct_in_if.sink                      in_req,
  ioct_out_if.source                   out_rsp,
  input  logic                         cfg_we,
  input  logic [ioct_pkg::TICK_W-1:0]  cfg_wdata
);

  localparam int ID_W   = ioct_pkg::ID_W;
  localparam int TYPE_W = ioct_pkg::TYPE_W;

  ioct_pkg::fifo_ctl_t   fifo_ctl;
  ioct_pkg::tmr_ctl_t    tmr_ctl;
  logic [ID_W-1:0]       head_id;
  logic [CNT_W-1:0]      count_nxt;
  logic                  full, empty, expired;
  logic                  accept;

  logic                  err_r, err_nxt;
  ioct_pkg::fault_code_t code_r, code_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;

  logic                  acc;
  logic [ID_W-1:0]       sid, did;
  logic [TYPE_W-1:0]     stype;
  logic                  dvalid;

  logic                  valid_r;
  logic                  acc_r, dvalid_r, fault_r;
  logic [ID_W-1:0]       sid_r, did_r;
  logic [TYPE_W-1:0]     stype_r;
  logic [2:0]            fcode_r;
  logic [CNT_W-1:0]      cnt_r;

  ioct_id_fifo #(
    .DEPTH (PENDING_DEPTH),
    .CNT_W (CNT_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fifo_ctl),
    .head_id   (head_id),
    .count_nxt (count_nxt),
    .full      (full),
    .empty     (empty)
  );

  ioct_timer u_timer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (tmr_ctl),
    .expired   (expired)
  );

  assign in_req.ready = !valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;

  // Decode the request and update tracker state
  always_comb begin
    fifo_ctl = '0;
    tmr_ctl  = '0;
    err_nxt  = err_r;
    code_nxt = code_r;
    id_nxt   = id_r;
    acc      = 1'b0;
    sid      = '0;
    stype    = '0;
    dvalid   = 1'b0;
    did      = '0;
    fifo_ctl.wdata = id_r + ID_W'(1);
    if (accept) begin
      unique case (in_req.cmd)
        ioct_pkg::CMD_ISSUE: begin
          id_nxt = id_r + ID_W'(1);
          if (!err_r && !full) begin
            fifo_ctl.push = 1'b1;
            acc           = 1'b1;
            sid           = id_nxt;
            stype         = in_req.cmd_type;
          end
        end
        ioct_pkg::CMD_RESP: begin
          if (!err_r) begin
            tmr_ctl.clear = 1'b1;
            unique case (in_req.resp_type)
              ioct_pkg::RESP_DONE: begin
                if (empty) begin
                  err_nxt  = 1'b1;
                  code_nxt = ioct_pkg::FC_UNEXPECTED;
                end else if (head_id == in_req.resp_id) begin
                  fifo_ctl.pop = 1'b1;
                  dvalid       = 1'b1;
                  did          = in_req.resp_id;
                end else begin
                  err_nxt  = 1'b1;
                  code_nxt = ioct_pkg::FC_OOO_DONE;
                end
              end
              ioct_pkg::RESP_ERROR: begin
                err_nxt  = 1'b1;
                code_nxt = ioct_pkg::FC_ERR_REPLY;
              end
              ioct_pkg::RESP_ESTOP: begin
                err_nxt = err_r;
              end
              ioct_pkg::RESP_UNKNOWN: begin
                err_nxt  = 1'b1;
                code_nxt = ioct_pkg::FC_UNKNOWN;
              end
            endcase
          end
        end
        ioct_pkg::CMD_TICK: begin
          if (!err_r && !empty) begin
            tmr_ctl.tick = 1'b1;
            if (expired) begin
              err_nxt  = 1'b1;
              code_nxt = ioct_pkg::FC_TIMEOUT;
            end
          end
        end
        default: begin
          err_nxt = err_r;
        end
      endcase
    end
  end

  // Hold fault state and the ID counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r  <= 1'b0;
      code_r <= ioct_pkg::FC_UNKNOWN;
      id_r   <= '0;
    end else begin
      err_r  <= err_nxt;
      code_r <= code_nxt;
      id_r   <= id_nxt;
    end
  end

  // Result valid: set on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      acc_r    <= acc;
      sid_r    <= sid;
      stype_r  <= stype;
      dvalid_r <= dvalid;
      did_r    <= did;
      fault_r  <= err_nxt;
      fcode_r  <= err_nxt ? code_nxt : ioct_pkg::FC_UNKNOWN;
      cnt_r    <= count_nxt;
    end
  end

  assign out_rsp.valid         = valid_r;
  assign out_rsp.accepted      = acc_r;
  assign out_rsp.send_id       = sid_r;
  assign out_rsp.send_type     = stype_r;
  assign out_rsp.done_valid    = dvalid_r;
  assign out_rsp.done_id       = did_r;
  assign out_rsp.fault         = fault_r;
  assign out_rsp.fault_code    = fcode_r;
  assign out_rsp.pending_count = cnt_r;

endmodule

>>> rtl/ioct_id_fifo.sv
// Queue of pending command IDs with a registered head read.
module ioct_id_fifo #(
  parameter int DEPTH = ioct_pkg::PENDING_DEPTH,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ioct_pkg::fifo_ctl_t        ctl,
  output logic [ioct_pkg::ID_W-1:0]  head_id,
  output logic [CNT_W-1:0]           count_nxt,
  output logic                       full,
  output logic                       empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [ioct_pkg::ID_W-1:0] mem [DEPTH];
  logic [ioct_pkg::ID_W-1:0] head_data_r;
  logic [PTR_W-1:0]          head_r, head_nxt;
  logic [PTR_W-1:0]          tail_r, tail_nxt;
  logic [CNT_W-1:0]          count_r;

  // Advance pointers with wrap at the depth
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.pop) begin
      head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end
    if (ctl.push) begin
      tail_nxt  = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Write at the tail; prefetch the next head, forwarding a same-cycle write
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= ctl.wdata;
    end
    if (ctl.push && (tail_r == head_nxt)) begin
      head_data_r <= ctl.wdata;
    end else begin
      head_data_r <= mem[head_nxt];
    end
  end

  assign head_id = head_data_r;
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);

endmodule

>>> rtl/ioct_timer.sv
// Timeout register and saturating wait-tick counter.
module ioct_timer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ioct_pkg::TICK_W-1:0]   cfg_wdata,
  input  ioct_pkg::tmr_ctl_t            ctl,
  output logic                          expired
);

  localparam int W = ioct_pkg::TICK_W;

  logic [W-1:0] timeout_r;
  logic [W-1:0] wait_r, wait_nxt;
  logic [W-1:0] wait_inc;

  // Saturate the count at all ones
  assign wait_inc = (&wait_r) ? wait_r : wait_r + W'(1);
  assign expired  = (wait_inc > timeout_r);

  always_comb begin
    wait_nxt = wait_r;
    if (ctl.clear) begin
      wait_nxt = '0;
    end else if (ctl.tick) begin
      wait_nxt = wait_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= ioct_pkg::TIMEOUT_RESET;
      wait_r    <= '0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      wait_r <= wait_nxt;
    end
  end

endmodule

>>> sim/completion_checker.sv
// Tracker result checker: mirrors the completion tracker and compares every result.
module completion_checker
  import ioct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ioct_in_if                req_mon,
  ioct_out_if               rsp_mon,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  output int                mismatches,
  output int                backlog
);

  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

  typedef struct packed {
    logic              accepted;
    logic [ID_W-1:0]   send_id;
    logic [TYPE_W-1:0] send_type;
    logic              done_valid;
    logic [ID_W-1:0]   done_id;
    logic              fault;
    fault_code_t       fault_code;
    logic [CNT_W-1:0]  pending_count;
  } tracker_status_t;

  // Mirrored tracker state
  logic [TICK_W-1:0] timeout_q;
  logic              faulted;
  fault_code_t       fault_kind;
  logic [ID_W-1:0]   next_id;
  logic [ID_W-1:0]   id_store [PENDING_DEPTH];
  int                rd_ptr;
  int                wr_ptr;
  int                held;
  logic [TICK_W-1:0] quiet_ticks;

  tracker_status_t   expected_status [$];
  tracker_status_t   want;

  function automatic void enter_fault(input fault_code_t code);
    faulted    = 1'b1;
    fault_kind = code;
  endfunction

  // Advance the mirrored state by one request and build its status
  function automatic tracker_status_t predict_status(input logic [1:0]        kind,
                                                     input logic [TYPE_W-1:0] ctype,
                                                     input logic [1:0]        rkind,
                                                     input logic [ID_W-1:0]   rid);
    tracker_status_t s;
    s = '0;
    case (kind)
      CMD_ISSUE: begin
        next_id = next_id + ID_W'(1);
        if (!faulted && held < PENDING_DEPTH) begin
          id_store[wr_ptr] = next_id;
          wr_ptr           = (wr_ptr + 1) % PENDING_DEPTH;
          held++;
          s.accepted  = 1'b1;
          s.send_id   = next_id;
          s.send_type = ctype;
        end
      end
      CMD_RESP: begin
        if (!faulted) begin
          quiet_ticks = '0;
          case (rkind)
            RESP_DONE: begin
              if (held == 0) begin
                enter_fault(FC_UNEXPECTED);
              end else if (id_store[rd_ptr] == rid) begin
                rd_ptr = (rd_ptr + 1) % PENDING_DEPTH;
                held--;
                s.done_valid = 1'b1;
                s.done_id    = rid;
              end else begin
                enter_fault(FC_OOO_DONE);
              end
            end
            RESP_ERROR:   enter_fault(FC_ERR_REPLY);
            RESP_UNKNOWN: enter_fault(FC_UNKNOWN);
            default: ;
          endcase
        end
      end
      CMD_TICK: begin
        // Count quiet time only while something is outstanding; saturate
        if (!faulted && held > 0) begin
          if (quiet_ticks != '1) quiet_ticks = quiet_ticks + TICK_W'(1);
          if (quiet_ticks > timeout_q) enter_fault(FC_TIMEOUT);
        end
      end
      default: ;
    endcase
    s.fault         = faulted;
    s.fault_code    = faulted ? fault_kind : FC_UNKNOWN;
    s.pending_count = CNT_W'(held);
    return s;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      timeout_q   = TIMEOUT_RESET;
      faulted     = 1'b0;
      fault_kind  = FC_UNKNOWN;
      next_id     = '0;
      rd_ptr      = 0;
      wr_ptr      = 0;
      held        = 0;
      quiet_ticks = '0;
      mismatches  = 0;
      expected_status.delete();
    end else begin
      // Compare the result taken at this edge against the oldest prediction
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_status.size() == 0) begin
          $error("result taken with no request outstanding");
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(rsp_mon.accepted));
          check_field("send_id", 32'(want.send_id), 32'(rsp_mon.send_id));
          check_field("send_type", 32'(want.send_type), 32'(rsp_mon.send_type));
          check_field("done_valid", 32'(want.done_valid), 32'(rsp_mon.done_valid));
          check_field("done_id", 32'(want.done_id), 32'(rsp_mon.done_id));
          check_field("fault", 32'(want.fault), 32'(rsp_mon.fault));
          check_field("fault_code", 32'(want.fault_code), 32'(rsp_mon.fault_code));
          check_field("pending_count", 32'(want.pending_count),
                      32'(rsp_mon.pending_count));
        end
      end
      if (cfg_we) timeout_q = cfg_wdata;
      // Predict the request accepted at this edge
      if (req_mon.valid && req_mon.ready) begin
        expected_status.push_back(predict_status(req_mon.cmd, req_mon.cmd_type,
                                                 req_mon.resp_type, req_mon.resp_id));
      end
    end
    backlog <= expected_status.size();
  end

endmodule

>>> sim/testbench.sv
// Simulation top for the completion tracker: clock, reset, traffic and verdict.
module testbench;
  import ioct_pkg::*;

  localparam int         CNT_W       = $clog2(PENDING_DEPTH + 1);
  localparam logic [1:0] CMD_NOP     = 2'd3;
  localparam int         HOLD_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [TICK_W-1:0] cfg_wdata;
  int                mismatches;
  int                backlog;

  // Sender bookkeeping
  int                burst_left = 0;
  int                issues_sent = 0;
  int                replies_sent = 0;
  int                ticks_sent = 0;
  int                nops_sent = 0;
  int                holds_asked = 0;
  int                holds_done = 0;

  // Light view of the tracker, used only to shape well-formed traffic
  logic [ID_W-1:0]   open_ids [$];
  logic [ID_W-1:0]   id_seq = '0;
  logic [TICK_W-1:0] idle_ticks = '0;
  logic [TICK_W-1:0] tick_limit = TIMEOUT_RESET;
  logic              tracker_faulted = 1'b0;

  ioct_in_if                 in_ch ();
  ioct_out_if #(.CNT_W(CNT_W)) out_ch ();

  always #10 clk = ~clk;

  in_order_completion_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_rsp   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  completion_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_ch),
    .rsp_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  // Offer one request, in bursts with random gaps, and hold it until taken
  task automatic push_request(input logic [1:0] kind, input logic [TYPE_W-1:0] ctype,
                              input logic [1:0] rkind, input logic [ID_W-1:0] rid);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(99) < 30) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= kind;
    in_ch.cmd_type  <= ctype;
    in_ch.resp_type <= rkind;
    in_ch.resp_id   <= rid;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (kind)
      CMD_ISSUE: issues_sent++;
      CMD_RESP:  replies_sent++;
      CMD_TICK:  ticks_sent++;
      default:   nops_sent++;
    endcase
  endtask

  task automatic issue_cmd(input logic [TYPE_W-1:0] ctype);
    id_seq = id_seq + ID_W'(1);
    if (!tracker_faulted && open_ids.size() < PENDING_DEPTH) open_ids.push_back(id_seq);
    push_request(CMD_ISSUE, ctype, 2'($urandom_range(3)), ID_W'($urandom_range(255)));
  endtask

  task automatic reply(input resp_kind_t rkind, input logic [ID_W-1:0] rid);
    if (!tracker_faulted) begin
      idle_ticks = '0;
      if (rkind == RESP_DONE && open_ids.size() > 0 && open_ids[0] == rid) begin
        void'(open_ids.pop_front());
      end else if (rkind != RESP_ESTOP) begin
        tracker_faulted = 1'b1;
      end
    end
    push_request(CMD_RESP, TYPE_W'($urandom_range(255)), rkind, rid);
  endtask

  task automatic tick();
    if (!tracker_faulted && open_ids.size() > 0) begin
      idle_ticks = idle_ticks + TICK_W'(1);
      if (idle_ticks > tick_limit) tracker_faulted = 1'b1;
    end
    push_request(CMD_TICK, TYPE_W'($urandom_range(255)), 2'($urandom_range(3)),
                 ID_W'($urandom_range(255)));
  endtask

  // Drop valid and wait for every outstanding result to drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [TICK_W-1:0] limit);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tick_limit = limit;
  endtask

  // Well-formed random traffic: dones retire the head, ticks stay within the timeout
  task automatic run_phase(input int count, input int w_issue, input int w_done,
                           input int w_tick);
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < w_issue) begin
        issue_cmd(TYPE_W'($urandom_range(255)));
      end else if (r < w_issue + w_done) begin
        if (open_ids.size() > 0) reply(RESP_DONE, open_ids[0]);
        else reply(RESP_ESTOP, ID_W'($urandom_range(255)));
      end else if (r < w_issue + w_done + w_tick) begin
        if (open_ids.size() == 0 || idle_ticks < tick_limit) tick();
        else reply(RESP_ESTOP, ID_W'($urandom_range(255)));
      end else if ($urandom_range(1) == 1) begin
        reply(RESP_ESTOP, ID_W'($urandom_range(255)));
      end else begin
        push_request(CMD_NOP, TYPE_W'($urandom_range(255)), 2'($urandom_range(3)),
                     ID_W'($urandom_range(255)));
      end
    end
  endtask

  // Drive the tracker into its sticky fault along the chosen path
  task automatic cause_fault(input fault_code_t code);
    case (code)
      FC_ERR_REPLY: reply(RESP_ERROR, ID_W'($urandom_range(255)));
      FC_UNKNOWN:   reply(RESP_UNKNOWN, ID_W'($urandom_range(255)));
      FC_UNEXPECTED: begin
        while (open_ids.size() > 0) reply(RESP_DONE, open_ids[0]);
        reply(RESP_DONE, ID_W'($urandom_range(255)));
      end
      FC_OOO_DONE: begin
        if (open_ids.size() == 0) issue_cmd(TYPE_W'($urandom_range(255)));
        reply(RESP_DONE, open_ids[0] ^ ID_W'($urandom_range(255, 1)));
      end
      default: begin
        set_timeout($urandom_range(3));
        if (open_ids.size() == 0) issue_cmd(TYPE_W'($urandom_range(255)));
        while (!tracker_faulted) tick();
      end
    endcase
  endtask

  initial begin : stimulus
    fault_code_t final_fault;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= TIMEOUT_RESET;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_ISSUE;
    in_ch.cmd_type  <= '0;
    in_ch.resp_type <= RESP_DONE;
    in_ch.resp_id   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle status, empty-queue tick and stop, extreme types, in-order retire
    push_request(CMD_NOP, 8'hFF, RESP_UNKNOWN, 8'hFF);
    tick();
    reply(RESP_ESTOP, 8'h00);
    issue_cmd(8'h00);
    issue_cmd(8'hFF);
    issue_cmd(8'h5A);
    tick();
    tick();
    reply(RESP_ESTOP, 8'hFF);
    reply(RESP_DONE, open_ids[0]);
    tick();
    reply(RESP_DONE, open_ids[0]);
    issue_cmd(8'hA5);
    reply(RESP_DONE, open_ids[0]);
    reply(RESP_DONE, open_ids[0]);
    tick();
    reply(RESP_ESTOP, 8'h3C);

    // Random phases across timeout settings; the second one favours issues so the queue tends to fill
    set_timeout(1);
    run_phase(420, 45, 30, 15);
    set_timeout($urandom_range(12, 2));
    run_phase(420, 60, 20, 15);
    set_timeout({TICK_W{1'b1}});
    run_phase(420, 30, 30, 35);
    set_timeout(TIMEOUT_RESET);
    run_phase(60, 40, 40, 10);
    // Hold the result side off while requests keep coming
    holds_asked++;
    run_phase(360, 50, 35, 10);

    // End in one sticky fault, then check that everything after it is ignored
    final_fault = fault_code_t'($urandom_range(4));
    cause_fault(final_fault);
    repeat (40) begin
      push_request(2'($urandom_range(3)), TYPE_W'($urandom_range(255)),
                   2'($urandom_range(3)), ID_W'($urandom_range(255)));
    end
    settle();

    $display("Sent %0d requests: %0d issues, %0d replies, %0d ticks, %0d no-ops.",
             issues_sent + replies_sent + ticks_sent + nops_sent, issues_sent,
             replies_sent, ticks_sent, nops_sent);
    $display("Timeouts from 1 to max, %0d long result hold(s), final fault %s.",
             holds_done, final_fault.name());
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: stall in segments of random style, plus long holds on request
  initial begin : result_sink
    int seg_left;
    int stall_style;
    out_ch.ready <= 1'b0;
    seg_left = 0;
    stall_style = 0;
    forever begin
      @(posedge clk);
      if (holds_done < holds_asked) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        if (seg_left == 0) begin
          seg_left    = $urandom_range(80, 10);
          stall_style = $urandom_range(2);
        end
        seg_left--;
        case (stall_style)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(99) < 70);
          default: out_ch.ready <= ($urandom_range(99) < 25);
        endcase
      end
    end
  end

  // Give up on a hung run
  initial begin : watchdog
    #(20 * 400000);
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
rtl/ioct_pkg.sv
rtl/ioct_if.sv
rtl/ioct_id_fifo.sv
rtl/ioct_timer.sv
rtl/in_order_completion_tracker.sv
sim/completion_checker.sv
sim/testbench.sv
